// ===== design/dlr_pkg.sv =====
`timescale 1ns / 1ps

package dlr_pkg;

   // Kind of request, carried on req_tuser
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } state_type;

   // Divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== design/dlr_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider: quotient = (mag << FRAC_BITS) / den, one quotient bit per cycle.
// den must be nonzero; mag and den are unsigned.
module dlr_divider #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [COORD_BITS-1:0]           mag,
   input  logic [COORD_BITS-1:0]           den,
   output logic [COORD_BITS+FRAC_BITS-1:0] quotient,
   output dlr_pkg::div_status_type         status
);
   import dlr_pkg::*;

   localparam int Q_W   = COORD_BITS + FRAC_BITS;
   localparam int CNT_W = $clog2(Q_W + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(Q_W - 1);

   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]        quo_ff, quo_in;
   logic [COORD_BITS-1:0] den_ff, den_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [COORD_BITS:0]   shifted;
   logic [COORD_BITS:0]   diff;
   logic                  fits;

   // One trial subtract per cycle
   assign shifted = {rem_ff, quo_ff[Q_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = ~diff[COORD_BITS];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = {mag, {FRAC_BITS{1'b0}}};
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
         quo_in = {quo_ff[Q_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== design/dda_line_rasterizer_top.sv =====
`timescale 1ns / 1ps

// DDA line rasterizer.
// Request channel (req_*): req_tuser selects the kind. A start transfer (tuser 0) carries
// both endpoints in req_tdata; a step transfer (tuser 1) asks for the next pixel.
// Response channel (rsp_*): exactly one transfer per request, in order. rsp_tdata holds
// the pixel, rsp_tuser is pixel_valid (0 for a step with no line active, data then zero),
// rsp_tlast marks the last pixel of the line.
// The response is registered and appears in the cycle after the request transfer.
// Pixels stream at one per cycle while rsp_tready is high and no divide runs. A start whose
// line needs a slope runs the restoring divider, one quotient bit per cycle, and req_tready
// stays low until the slope is loaded; the first pixel is already offered on rsp while the
// divide runs.
// A start with end_x below start_x, or a vertical one (end_x equal to start_x), needs no
// divide; horizontal and sloped lines do.
// The block holds one response; while rsp_tready is low with a response waiting, req_tready
// stays low and nothing is lost.
// Reset (synchronous, active high) leaves no line active and no response pending.
module dda_line_rasterizer_top #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // start_x, start_y, end_x, end_y from the lowest bit up
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   // func
   input  logic                                     req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // pixel_x, pixel_y from the lowest bit up
   output logic [((2*COORD_BITS+7)/8)*8-1:0]        rsp_tdata,
   // pixel_valid
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);
   import dlr_pkg::*;

   localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
   localparam int Q_W   = COORD_BITS + FRAC_BITS;
   localparam int RSP_W = ((2*COORD_BITS+7)/8)*8;
   localparam logic [ACC_W-1:0] ONE_FIX = ACC_W'(1) << FRAC_BITS;

   state_type            state_ff, state_in;
   logic [ACC_W-1:0]     x_acc_ff, x_acc_in;
   logic [ACC_W-1:0]     y_acc_ff, y_acc_in;
   logic [ACC_W-1:0]     x_inc_ff, x_inc_in;
   logic [ACC_W-1:0]     y_inc_ff, y_inc_in;
   logic [COORD_BITS-1:0] steps_ff, steps_in;
   logic                 active_ff, active_in;
   logic                 neg_ff, neg_in;
   logic                 minor_y_ff, minor_y_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic                 rsp_pv_ff, rsp_pv_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [COORD_BITS-1:0] sx, sy, ex, ey;
   logic signed [COORD_BITS:0] dx, dy;
   logic [COORD_BITS-1:0] abs_dy;
   logic                 req_xfer;

   logic                 div_start;
   logic [COORD_BITS-1:0] div_mag, div_den;
   logic [Q_W-1:0]       div_q;
   div_status_type       div_st;
   logic [ACC_W-1:0]     slope;

   assign sx = req_tdata[COORD_BITS-1:0];
   assign sy = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign ex = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign ey = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
   assign dx = $signed({1'b0, ex}) - $signed({1'b0, sx});
   assign dy = $signed({1'b0, ey}) - $signed({1'b0, sy});
   assign abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   assign slope = neg_ff ? ACC_W'(0) - {1'b0, div_q} : {1'b0, div_q};

   always_comb begin
      state_in    = state_ff;
      x_acc_in    = x_acc_ff;
      y_acc_in    = y_acc_ff;
      x_inc_in    = x_inc_ff;
      y_inc_in    = y_inc_ff;
      steps_in    = steps_ff;
      active_in   = active_ff;
      neg_in      = neg_ff;
      minor_y_in  = minor_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_pv_in   = rsp_pv_ff;
      rsp_last_in = rsp_last_ff;
      div_start   = 1'b0;
      div_mag     = abs_dy;
      div_den     = dx[COORD_BITS-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_tuser == FUNC_START) begin
               x_acc_in = {1'b0, sx, {FRAC_BITS{1'b0}}};
               y_acc_in = {1'b0, sy, {FRAC_BITS{1'b0}}};
               x_inc_in = '0;
               y_inc_in = '0;
               steps_in = '0;
               if (dx[COORD_BITS]) begin
                  steps_in = '0;
               end else if (dx == '0) begin
                  y_inc_in = ONE_FIX;
                  steps_in = (dy > 0) ? dy[COORD_BITS-1:0] : '0;
               end else if (dy <= dx) begin
                  x_inc_in   = ONE_FIX;
                  steps_in   = dx[COORD_BITS-1:0];
                  neg_in     = dy[COORD_BITS];
                  minor_y_in = 1'b1;
                  div_start  = 1'b1;
                  state_in   = ST_DIV;
               end else begin
                  y_inc_in   = ONE_FIX;
                  steps_in   = dy[COORD_BITS-1:0];
                  neg_in     = 1'b0;
                  minor_y_in = 1'b0;
                  div_mag    = dx[COORD_BITS-1:0];
                  div_den    = dy[COORD_BITS-1:0];
                  div_start  = 1'b1;
                  state_in   = ST_DIV;
               end
               active_in    = (steps_in != '0);
               rsp_valid_in = 1'b1;
               rsp_x_in     = sx;
               rsp_y_in     = sy;
               rsp_pv_in    = 1'b1;
               rsp_last_in  = (steps_in == '0);
            end else if (req_xfer) begin
               rsp_valid_in = 1'b1;
               if (active_ff) begin
                  x_acc_in    = x_acc_ff + x_inc_ff;
                  y_acc_in    = y_acc_ff + y_inc_ff;
                  steps_in    = steps_ff - COORD_BITS'(1);
                  active_in   = (steps_in != '0);
                  rsp_x_in    = x_acc_in[Q_W-1:FRAC_BITS];
                  rsp_y_in    = y_acc_in[Q_W-1:FRAC_BITS];
                  rsp_pv_in   = 1'b1;
                  rsp_last_in = !active_in;
               end else begin
                  rsp_x_in    = '0;
                  rsp_y_in    = '0;
                  rsp_pv_in   = 1'b0;
                  rsp_last_in = 1'b0;
               end
            end
         end
         ST_DIV: begin
            if (div_st.done) begin
               if (minor_y_ff) begin
                  y_inc_in = slope;
               end else begin
                  x_inc_in = slope;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_acc_ff     <= '0;
         y_acc_ff     <= '0;
         x_inc_ff     <= '0;
         y_inc_ff     <= '0;
         steps_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_acc_ff     <= x_acc_in;
         y_acc_ff     <= y_acc_in;
         x_inc_ff     <= x_inc_in;
         y_inc_ff     <= y_inc_in;
         steps_ff     <= steps_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      minor_y_ff  <= minor_y_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_last_ff <= rsp_last_in;
   end

   dlr_divider #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .mag      (div_mag),
      .den      (div_den),
      .quotient (div_q),
      .status   (div_st)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_pv_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_req_during_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !req_tready)
      else $error("request taken while slope divide in progress");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");

   a_active_matches_steps: assert property (@(posedge clock) disable iff (reset)
      active_ff == (steps_ff != '0))
      else $error("line active flag disagrees with step count");

   a_div_start_leads_busy: assert property (@(posedge clock) disable iff (reset)
      div_start |=> div_st.busy)
      else $error("divider not busy after start");

endmodule
